[hw/rtl/ecpf_pkg.sv]
// Shared types, constants and helper functions for the excluded-pair Coulomb core.
package ecpf_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_COULOMB   = 2'd0;
    localparam logic [1:0] REG_SF_ONE    = 2'd1;
    localparam logic [1:0] REG_SF_TWO    = 2'd2;
    localparam logic [1:0] REG_SF_THREE  = 2'd3;

    // Exclusion class codes
    localparam logic [1:0] CLASS_SKIP  = 2'd0;
    localparam logic [1:0] CLASS_ONE   = 2'd1;
    localparam logic [1:0] CLASS_TWO   = 2'd2;
    localparam logic [1:0] CLASS_THREE = 2'd3;

    // 1.0 in Q1.16 and 3.0 in Q2.30
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [31:0] THREE_Q30  = 32'hC000_0000;

    localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;

    // Classified request as it sits in the queue
    typedef struct packed {
        logic             skip;
        logic             sneg;
        logic [2:0]       dn;
        logic [2:0][31:0] dm;
        logic [15:0]      qa_mag;
        logic [15:0]      qb_mag;
        logic [16:0]      fm;
    } q_entry_t;

    // Side data that rides along the reciprocal square root pipeline
    typedef struct packed {
        logic             skip;
        logic             zero;
        logic             sneg;
        logic [2:0]       dn;
        logic [2:0][31:0] dm;
        logic [79:0]      c;
        logic signed [4:0] h;
    } side_t;

    // Seed of 1/sqrt(m) for m in [1,4), indexed by m[31:28], Q0.16
    function automatic logic [15:0] seed_lut(input logic [3:0] idx);
        logic [15:0] s;
        unique case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: s = 16'd61788;
            4'd5:  s = 16'd55889;
            4'd6:  s = 16'd51411;
            4'd7:  s = 16'd47861;
            4'd8:  s = 16'd44957;
            4'd9:  s = 16'd42525;
            4'd10: s = 16'd40450;
            4'd11: s = 16'd38651;
            4'd12: s = 16'd37073;
            4'd13: s = 16'd35673;
            4'd14: s = 16'd34421;
            4'd15: s = 16'd33292;
            default: s = 16'd33292;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    // Apply sign to a magnitude and clamp to signed 64 bits
    function automatic logic [63:0] sat64(input logic [127:0] mag, input logic neg);
        logic [63:0] r;
        if (neg) begin
            if ((|mag[127:64]) || (mag[63:0] > SAT_NEG)) r = SAT_NEG;
            else r = ~mag[63:0] + 64'd1;
        end else begin
            if (|mag[127:63]) r = SAT_POS;
            else r = mag[63:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/ecpf_front.sv]
// Front end: configuration registers, request acceptance and classification.
module ecpf_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [31:0]     s_disp_x,
    input  logic signed [31:0]     s_disp_y,
    input  logic signed [31:0]     s_disp_z,
    input  logic signed [15:0]     s_charge_a,
    input  logic signed [15:0]     s_charge_b,
    input  logic [1:0]             s_special_class,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output ecpf_pkg::q_entry_t     q_entry,
    output logic [31:0]            coulomb_const
);

    logic [31:0] coulomb_const_reg;
    logic [16:0] sf_one_reg;
    logic [16:0] sf_two_reg;
    logic [16:0] sf_three_reg;
    logic [16:0] sf;
    logic        fneg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coulomb_const_reg <= '0;
            sf_one_reg        <= '0;
            sf_two_reg        <= '0;
            sf_three_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ecpf_pkg::REG_COULOMB:  coulomb_const_reg <= cfg_data;
                ecpf_pkg::REG_SF_ONE:   sf_one_reg        <= cfg_data[16:0];
                ecpf_pkg::REG_SF_TWO:   sf_two_reg        <= cfg_data[16:0];
                ecpf_pkg::REG_SF_THREE: sf_three_reg      <= cfg_data[16:0];
            endcase
        end
    end

    assign cfg_ready     = 1'b1;
    assign coulomb_const = coulomb_const_reg;

    // Classify: magnitudes, signs, factor
    always_comb begin
        unique case (s_special_class)
            ecpf_pkg::CLASS_SKIP:  sf = '0;
            ecpf_pkg::CLASS_ONE:   sf = sf_one_reg;
            ecpf_pkg::CLASS_TWO:   sf = sf_two_reg;
            ecpf_pkg::CLASS_THREE: sf = sf_three_reg;
        endcase
        fneg = sf < ecpf_pkg::ONE_Q16;
        q_entry.skip   = s_special_class == ecpf_pkg::CLASS_SKIP;
        q_entry.fm     = fneg ? (ecpf_pkg::ONE_Q16 - sf) : (sf - ecpf_pkg::ONE_Q16);
        q_entry.sneg   = fneg ^ s_charge_a[15] ^ s_charge_b[15];
        q_entry.dn     = {s_disp_z[31], s_disp_y[31], s_disp_x[31]};
        q_entry.dm[0]  = ecpf_pkg::mag32(s_disp_x);
        q_entry.dm[1]  = ecpf_pkg::mag32(s_disp_y);
        q_entry.dm[2]  = ecpf_pkg::mag32(s_disp_z);
        q_entry.qa_mag = ecpf_pkg::mag16(s_charge_a);
        q_entry.qb_mag = ecpf_pkg::mag16(s_charge_b);
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

[hw/rtl/ecpf_queue.sv]
// Short queue between the front end and the arithmetic pipeline.
module ecpf_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  ecpf_pkg::q_entry_t wr_entry,
    output logic               full,
    input  logic               pop,
    output ecpf_pkg::q_entry_t rd_entry,
    output logic               empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ecpf_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CNT_W'(1);
        else if (!push && pop) count_next = count_reg - CNT_W'(1);
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign rd_entry = mem_reg[rd_ptr_reg];
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

endmodule

[hw/rtl/ecpf_prep.sv]
// Squared distance, Coulomb prefactor and normalization of rsq into m * 4^h.
module ecpf_prep (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ecpf_pkg::q_entry_t in_entry,
    input  logic [31:0]        coulomb_const,
    output logic               out_valid,
    output logic [31:0]        out_m,
    output ecpf_pkg::side_t    out_side
);

    // Stage 1
    logic             v1_reg;
    logic [2:0][63:0] sq1_reg;
    logic [30:0]      qm1_reg;
    logic [48:0]      fk1_reg;
    logic             skip1_reg, sneg1_reg;
    logic [2:0]       dn1_reg;
    logic [2:0][31:0] dm1_reg;
    // Stage 2
    logic             v2_reg;
    logic [63:0]      raw2_reg;
    logic [55:0]      cl2_reg;
    logic [54:0]      ch2_reg;
    logic             skip2_reg, sneg2_reg;
    logic [2:0]       dn2_reg;
    logic [2:0][31:0] dm2_reg;
    // Stage 3
    logic             v3_reg;
    logic [63:0]      raw3_reg;
    logic [3:0]       nz3_reg;
    logic [3:0][3:0]  pos3_reg;
    logic [79:0]      c3_reg;
    logic             skip3_reg, sneg3_reg;
    logic [2:0]       dn3_reg;
    logic [2:0][31:0] dm3_reg;
    // Stage 4
    logic             v4_reg;
    logic [63:0]      raw4_reg;
    logic [5:0]       k2_4_reg;
    ecpf_pkg::side_t  side4_reg;
    // Stage 5
    logic             v5_reg;
    logic [31:0]      m5_reg;
    ecpf_pkg::side_t  side5_reg;

    logic [3:0]       nz_next;
    logic [3:0][3:0]  pos_next;
    logic [5:0]       p_next;
    logic [93:0]      norm_next;

    // Leading one within each 16-bit chunk
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            nz_next[j]  = |raw2_reg[16*j +: 16];
            pos_next[j] = '0;
            for (int b = 0; b < 16; b++) begin
                if (raw2_reg[16*j + b]) pos_next[j] = 4'(b);
            end
        end
    end

    // Combine chunks into the top bit position
    always_comb begin
        p_next = '0;
        for (int j = 0; j < 4; j++) begin
            if (nz3_reg[j]) p_next = {2'(j), pos3_reg[j]};
        end
    end

    assign norm_next = {raw4_reg, 30'b0} >> k2_4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // squares, charge product, factor times constant
            for (int a = 0; a < 3; a++) sq1_reg[a] <= in_entry.dm[a] * in_entry.dm[a];
            qm1_reg   <= in_entry.qa_mag * in_entry.qb_mag;
            fk1_reg   <= in_entry.fm * coulomb_const;
            skip1_reg <= in_entry.skip;
            sneg1_reg <= in_entry.sneg;
            dn1_reg   <= in_entry.dn;
            dm1_reg   <= in_entry.dm;
            // rsq and split prefactor products
            raw2_reg  <= sq1_reg[0] + sq1_reg[1] + sq1_reg[2];
            cl2_reg   <= fk1_reg[24:0] * qm1_reg;
            ch2_reg   <= fk1_reg[48:25] * qm1_reg;
            skip2_reg <= skip1_reg;
            sneg2_reg <= sneg1_reg;
            dn2_reg   <= dn1_reg;
            dm2_reg   <= dm1_reg;
            // chunk search, prefactor sum
            raw3_reg  <= raw2_reg;
            nz3_reg   <= nz_next;
            pos3_reg  <= pos_next;
            c3_reg    <= 80'(cl2_reg) + {ch2_reg, 25'b0};
            skip3_reg <= skip2_reg;
            sneg3_reg <= sneg2_reg;
            dn3_reg   <= dn2_reg;
            dm3_reg   <= dm2_reg;
            // exponent: k2 = 2h + 32
            raw4_reg       <= raw3_reg;
            k2_4_reg       <= {p_next[5:1], 1'b0};
            side4_reg.skip <= skip3_reg;
            side4_reg.zero <= ~|nz3_reg;
            side4_reg.sneg <= sneg3_reg;
            side4_reg.dn   <= dn3_reg;
            side4_reg.dm   <= dm3_reg;
            side4_reg.c    <= c3_reg;
            side4_reg.h    <= {~p_next[5], p_next[4:1]};
            // mantissa in Q2.30
            m5_reg    <= norm_next[31:0];
            side5_reg <= side4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_m     = m5_reg;
    assign out_side  = side5_reg;

endmodule

[hw/rtl/ecpf_rsqrt.sv]
// Pipelined reciprocal square root: seed lookup then Newton steps, four stages each.
module ecpf_rsqrt #(
    parameter int STEPS = 3
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [31:0]     in_m,
    input  ecpf_pkg::side_t in_side,
    output logic            out_valid,
    output logic [31:0]     out_y,
    output ecpf_pkg::side_t out_side
);

    logic            vs_reg;
    logic [31:0]     ms_reg;
    logic [31:0]     ys_reg;
    ecpf_pkg::side_t ss_reg;

    logic [STEPS:0]        v_w;
    logic [STEPS:0][31:0]  m_w;
    logic [STEPS:0][31:0]  y_w;
    ecpf_pkg::side_t       s_w [STEPS+1];

    // Seed stage
    always_ff @(posedge aclk) begin
        if (!aresetn) vs_reg <= 1'b0;
        else if (en) vs_reg <= in_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ms_reg <= in_m;
            ys_reg <= {2'b0, ecpf_pkg::seed_lut(in_m[31:28]), 14'b0};
            ss_reg <= in_side;
        end
    end

    assign v_w[0] = vs_reg;
    assign m_w[0] = ms_reg;
    assign y_w[0] = ys_reg;
    assign s_w[0] = ss_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        logic            va_reg, vb_reg, vc_reg, vd_reg;
        logic [31:0]     ya_reg, yb_reg, yc_reg;
        logic [31:0]     ma_reg, mb_reg, mc_reg, md_reg;
        ecpf_pkg::side_t sa_reg, sb_reg, sc_reg, sd_reg;
        logic [63:0]     yy_reg;
        logic [65:0]     pr_reg;
        logic [31:0]     t_reg;
        logic [63:0]     yt_reg;
        logic [35:0]     pq;
        logic [31:0]     t_next;

        // t = 3 - m*y^2, floored at zero
        assign pq     = pr_reg[65:30];
        assign t_next = (pq >= 36'(ecpf_pkg::THREE_Q30)) ? '0
                      : 32'(36'(ecpf_pkg::THREE_Q30) - pq);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                va_reg <= 1'b0;
                vb_reg <= 1'b0;
                vc_reg <= 1'b0;
                vd_reg <= 1'b0;
            end else if (en) begin
                va_reg <= v_w[i];
                vb_reg <= va_reg;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                yy_reg <= y_w[i] * y_w[i];
                ya_reg <= y_w[i];
                ma_reg <= m_w[i];
                sa_reg <= s_w[i];
                pr_reg <= ma_reg * yy_reg[63:30];
                yb_reg <= ya_reg;
                mb_reg <= ma_reg;
                sb_reg <= sa_reg;
                t_reg  <= t_next;
                yc_reg <= yb_reg;
                mc_reg <= mb_reg;
                sc_reg <= sb_reg;
                yt_reg <= yc_reg * t_reg;
                md_reg <= mc_reg;
                sd_reg <= sc_reg;
            end
        end

        assign v_w[i+1] = vd_reg;
        assign m_w[i+1] = md_reg;
        assign y_w[i+1] = yt_reg[62:31];
        assign s_w[i+1] = sd_reg;
    end

    assign out_valid = v_w[STEPS];
    assign out_y     = y_w[STEPS];
    assign out_side  = s_w[STEPS];

endmodule

[hw/rtl/ecpf_scale.sv]
// Back end: scales 1/r into energy and force, shifts, saturates, output register.
module ecpf_scale (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [31:0]     in_y,
    input  ecpf_pkg::side_t in_side,
    output logic            out_valid,
    output logic [63:0]     out_force_x,
    output logic [63:0]     out_force_y,
    output logic [63:0]     out_force_z,
    output logic [63:0]     out_energy,
    output logic            out_skipped,
    output logic            out_zero_distance
);

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    ecpf_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;

    // F1
    logic [63:0]      yy1_reg;
    logic [2:0][63:0] dmy1_reg;
    logic [58:0]      cy0_1_reg, cy1_1_reg;
    logic [57:0]      cy2_1_reg;
    // F2
    logic [111:0]     cy2_reg;
    logic [2:0][32:0] u2_reg;
    logic [60:0]      cg0_2_reg, cg1_2_reg;
    logic [59:0]      cg2_2_reg;
    // F3
    logic [111:0]     emag3_reg;
    logic [83:0]      g3_reg;
    logic [2:0][32:0] u3_reg;
    // F4
    logic [63:0]      e4_reg, e5_reg, e6_reg;
    logic [2:0][60:0] fp0_4_reg, fp1_4_reg, fp2_4_reg;
    // F5
    logic [2:0][116:0] fprod5_reg;
    // F6
    logic [2:0][116:0] fmag6_reg;
    // F7 output
    logic [2:0][63:0] force_reg;
    logic [63:0]      energy_reg;
    logic             skipped_reg;
    logic             zero_reg;

    logic [33:0]      y2_1;
    logic [4:0]       sh_u;
    logic [6:0]       sh_e;
    logic [6:0]       sh_f;
    logic [113:0]     cg_sum;
    logic             kill;

    assign y2_1   = yy1_reg[63:30];
    assign sh_u   = {~s1_reg.h[4], s1_reg.h[3:0]};
    assign sh_e   = {{2{s2_reg.h[4]}}, s2_reg.h} + 7'd54;
    assign sh_f   = {s5_reg.h[4], s5_reg.h, 1'b0} + 7'd54;
    assign cg_sum = 114'(cg0_2_reg) + 114'({cg1_2_reg, 27'b0}) + {cg2_2_reg, 54'b0};
    assign kill   = s6_reg.skip || s6_reg.zero;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // F1: y^2, |d|*y, C*y in three slices
            yy1_reg <= in_y * in_y;
            for (int a = 0; a < 3; a++) dmy1_reg[a] <= in_side.dm[a] * in_y;
            cy0_1_reg <= in_side.c[26:0] * in_y;
            cy1_1_reg <= in_side.c[53:27] * in_y;
            cy2_1_reg <= in_side.c[79:54] * in_y;
            s1_reg    <= in_side;
            // F2: unit vector, C*y sum, C*y2 slices
            for (int a = 0; a < 3; a++) begin
                u2_reg[a] <= 33'(dmy1_reg[a] >> sh_u);
            end
            cy2_reg   <= 112'(cy0_1_reg) + 112'({cy1_1_reg, 27'b0}) + {cy2_1_reg, 54'b0};
            cg0_2_reg <= s1_reg.c[26:0] * y2_1;
            cg1_2_reg <= s1_reg.c[53:27] * y2_1;
            cg2_2_reg <= s1_reg.c[79:54] * y2_1;
            s2_reg    <= s1_reg;
            // F3: energy shift, g = C*y2 >> 30
            emag3_reg <= cy2_reg >> sh_e;
            g3_reg    <= cg_sum[113:30];
            u3_reg    <= u2_reg;
            s3_reg    <= s2_reg;
            // F4: energy clamp, g*u slices
            e4_reg <= ecpf_pkg::sat64(128'(emag3_reg), s3_reg.sneg);
            for (int a = 0; a < 3; a++) begin
                fp0_4_reg[a] <= g3_reg[27:0] * u3_reg[a];
                fp1_4_reg[a] <= g3_reg[55:28] * u3_reg[a];
                fp2_4_reg[a] <= g3_reg[83:56] * u3_reg[a];
            end
            s4_reg <= s3_reg;
            // F5: force product sum
            for (int a = 0; a < 3; a++) begin
                fprod5_reg[a] <= 117'(fp0_4_reg[a]) + 117'({fp1_4_reg[a], 28'b0})
                               + {fp2_4_reg[a], 56'b0};
            end
            e5_reg <= e4_reg;
            s5_reg <= s4_reg;
            // F6: force shift
            for (int a = 0; a < 3; a++) fmag6_reg[a] <= fprod5_reg[a] >> sh_f;
            e6_reg <= e5_reg;
            s6_reg <= s5_reg;
            // F7: clamp, sign, special cases
            for (int a = 0; a < 3; a++) begin
                force_reg[a] <= kill ? '0
                              : ecpf_pkg::sat64(128'(fmag6_reg[a]), s6_reg.sneg ^ s6_reg.dn[a]);
            end
            energy_reg  <= kill ? '0 : e6_reg;
            skipped_reg <= s6_reg.skip;
            zero_reg    <= !s6_reg.skip && s6_reg.zero;
        end
    end

    assign out_valid         = v7_reg;
    assign out_force_x       = force_reg[0];
    assign out_force_y       = force_reg[1];
    assign out_force_z       = force_reg[2];
    assign out_energy        = energy_reg;
    assign out_skipped       = skipped_reg;
    assign out_zero_distance = zero_reg;

endmodule

[hw/rtl/excluded_coulomb_pair_force_core.sv]
// Top level of the excluded-pair Coulomb force core.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | disp x/y/z, charges, special class
//  m_      | out       | m_valid / m_ready    | force x/y/z, pair energy, flags
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pair per cycle sustained while the output is not stalled. The pipeline has
// five prep stages, a seed stage, four per Newton step and seven scale stages.
// The back pipeline advances as one unit whenever the output register is empty
// or being taken; the front queue keeps taking requests while it is stalled,
// until it fills. Reset clears the valid bits, queue pointers and configuration
// registers. cfg_ready is always high.
module excluded_coulomb_pair_force_core #(
    parameter int RSQRT_STEPS = 3,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_disp_x,
    input  logic signed [31:0] s_disp_y,
    input  logic signed [31:0] s_disp_z,
    input  logic signed [15:0] s_charge_a,
    input  logic signed [15:0] s_charge_b,
    input  logic [1:0]         s_special_class,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [63:0] m_force_x,
    output logic signed [63:0] m_force_y,
    output logic signed [63:0] m_force_z,
    output logic signed [63:0] m_pair_energy,
    output logic               m_skipped,
    output logic               m_zero_distance,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    ecpf_pkg::q_entry_t wr_entry, rd_entry;
    ecpf_pkg::side_t    prep_side, rs_side;
    logic               q_push, q_full, q_pop, q_empty;
    logic [31:0]        coulomb_const;
    logic               en;
    logic               prep_valid, rs_valid;
    logic [31:0]        prep_m, rs_y;

    // Whole back pipeline moves when the output slot frees up
    assign en    = !m_valid || m_ready;
    assign q_pop = en && !q_empty;

    ecpf_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_disp_x        (s_disp_x),
        .s_disp_y        (s_disp_y),
        .s_disp_z        (s_disp_z),
        .s_charge_a      (s_charge_a),
        .s_charge_b      (s_charge_b),
        .s_special_class (s_special_class),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (wr_entry),
        .coulomb_const   (coulomb_const)
    );

    ecpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    ecpf_prep u_prep (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (!q_empty),
        .in_entry      (rd_entry),
        .coulomb_const (coulomb_const),
        .out_valid     (prep_valid),
        .out_m         (prep_m),
        .out_side      (prep_side)
    );

    ecpf_rsqrt #(.STEPS(RSQRT_STEPS)) u_rsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (prep_valid),
        .in_m      (prep_m),
        .in_side   (prep_side),
        .out_valid (rs_valid),
        .out_y     (rs_y),
        .out_side  (rs_side)
    );

    ecpf_scale u_scale (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .in_valid          (rs_valid),
        .in_y              (rs_y),
        .in_side           (rs_side),
        .out_valid         (m_valid),
        .out_force_x       (m_force_x),
        .out_force_y       (m_force_y),
        .out_force_z       (m_force_z),
        .out_energy        (m_pair_energy),
        .out_skipped       (m_skipped),
        .out_zero_distance (m_zero_distance)
    );

endmodule

[hw/rtl/ecpf_checker.sv]
// Port-level checks for the excluded-pair Coulomb core, bound to the top level.
module ecpf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [31:0] s_disp_x,
    input logic signed [31:0] s_disp_y,
    input logic signed [31:0] s_disp_z,
    input logic signed [15:0] s_charge_a,
    input logic signed [15:0] s_charge_b,
    input logic [1:0]         s_special_class,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_force_x,
    input logic signed [63:0] m_force_y,
    input logic signed [63:0] m_force_z,
    input logic signed [63:0] m_pair_energy,
    input logic               m_skipped,
    input logic               m_zero_distance,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [1:0]         cfg_index,
    input logic [31:0]        cfg_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_x) && $stable(m_pair_energy)
        && $stable(m_skipped) && $stable(m_zero_distance))
        else $error("result changed while stalled");

    // Skipped pairs report zeros and never a zero distance
    a_skip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_skipped |-> !m_zero_distance && m_force_x == 0 && m_force_y == 0
        && m_force_z == 0 && m_pair_energy == 0)
        else $error("skipped pair with nonzero result");

    // Zero distance gives zero results
    a_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_distance |-> m_force_x == 0 && m_force_y == 0
        && m_force_z == 0 && m_pair_energy == 0)
        else $error("zero distance with nonzero result");

    // Nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind excluded_coulomb_pair_force_core ecpf_checker u_ecpf_checker (.*);
